// ===== rtl/chc_pkg.sv =====
// package: payload types, opcodes, cordic table and fixed-point constants
`default_nettype none
package chc_pkg;

	localparam int SAMPLE_BITS = 16;

	typedef enum logic [2:0] {
		OP_HEADING   = 3'd0,
		OP_ZERO      = 3'd1,
		OP_CAL_START = 3'd2,
		OP_CAL_SMP   = 3'd3,
		OP_CAL_END   = 3'd4
	} opcode_t;

	typedef struct packed {
		logic [2:0]                  opcode;
		logic signed [SAMPLE_BITS-1:0] sample_x;
		logic signed [SAMPLE_BITS-1:0] sample_y;
		logic                        data_ready;
		logic                        overflow_flag;
	} in_beat_t;

	typedef struct packed {
		logic [8:0] heading_deg;
		logic       fresh;
		logic       range_error;
	} out_beat_t;

	localparam int QW = 19;
	localparam int ZW = 27;
	localparam int FULL_TURN = 360;
	localparam logic signed [ZW-1:0] DEG90 = 27'sd5898240;
	localparam logic signed [ZW-1:0] TURN_Q16 = 27'sd23592960;

	typedef struct packed {
		logic start_div;
		logic start_cordic;
		logic sel_y;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic cordic_done;
	} dp_sts_t;

	function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0: r = 27'sd2949120;
			5'd1: r = 27'sd1740967;
			5'd2: r = 27'sd919879;
			5'd3: r = 27'sd466945;
			5'd4: r = 27'sd234379;
			5'd5: r = 27'sd117304;
			5'd6: r = 27'sd58666;
			5'd7: r = 27'sd29335;
			5'd8: r = 27'sd14668;
			5'd9: r = 27'sd7334;
			5'd10: r = 27'sd3667;
			5'd11: r = 27'sd1833;
			5'd12: r = 27'sd917;
			5'd13: r = 27'sd458;
			5'd14: r = 27'sd229;
			5'd15: r = 27'sd115;
			5'd16: r = 27'sd57;
			5'd17: r = 27'sd29;
			5'd18: r = 27'sd14;
			5'd19: r = 27'sd7;
			5'd20: r = 27'sd4;
			5'd21: r = 27'sd2;
			5'd22: r = 27'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/chc_ctrl.sv =====
// controller: sequences the divisions and the cordic for one heading beat
`default_nettype none
module chc_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              go,
	input  chc_pkg::dp_sts_t sts,
	output chc_pkg::dp_cmd_t cmd,
	output logic             busy
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIVX0 = 7'b0000010,
		S_DIVX  = 7'b0000100,
		S_DIVY0 = 7'b0001000,
		S_DIVY  = 7'b0010000,
		S_COR   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: if (go) state_d = S_DIVX0;
			S_DIVX0: begin
				cmd.start_div = 1'b1;
				state_d = S_DIVX;
			end
			S_DIVX: if (sts.div_done) state_d = S_DIVY0;
			S_DIVY0: begin
				cmd.start_div = 1'b1;
				cmd.sel_y = 1'b1;
				state_d = S_DIVY;
			end
			S_DIVY: begin
				cmd.sel_y = 1'b1;
				if (sts.div_done) begin
					cmd.start_cordic = 1'b1;
					state_d = S_COR;
				end
			end
			S_COR: if (sts.cordic_done) state_d = S_FIN;
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== rtl/chc_dpath.sv =====
// datapath: calibration registers, shared restoring divider, cordic, heading
`default_nettype none
module chc_dpath #(
	parameter int SAMPLE_BITS  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        load,
	input  wire [2:0]                  op,
	input  wire signed [SAMPLE_BITS-1:0] sx,
	input  wire signed [SAMPLE_BITS-1:0] sy,
	input  chc_pkg::dp_cmd_t           cmd,
	output chc_pkg::dp_sts_t           sts,
	output logic                       range_zero,
	output logic [8:0]                 heading
);
	localparam int SB = SAMPLE_BITS;
	localparam int NW = SB + 18;
	localparam int CW = $clog2(NW + 1);
	localparam int SW = $clog2(CORDIC_STEPS + 1);
	localparam int QW = chc_pkg::QW;
	localparam int ZW = chc_pkg::ZW;
	localparam int XW = QW + 3;
	localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};

	logic signed [SB-1:0] tx_max_q, tx_min_q, ty_max_q, ty_min_q;
	logic signed [SB-1:0] cx_min_q, cy_min_q;
	logic [SB-1:0] cx_rng_q, cy_rng_q;
	logic signed [SB-1:0] hx_q, hy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_max_q <= SMIN; ty_max_q <= SMIN;
			tx_min_q <= SMAX; ty_min_q <= SMAX;
			cx_min_q <= '0; cy_min_q <= '0;
			cx_rng_q <= '0; cy_rng_q <= '0;
		end else if (load) begin
			case (op)
				chc_pkg::OP_CAL_START: begin
					tx_max_q <= SMIN; ty_max_q <= SMIN;
					tx_min_q <= SMAX; ty_min_q <= SMAX;
				end
				chc_pkg::OP_CAL_SMP: begin
					if (sx > tx_max_q) tx_max_q <= sx;
					if (sx < tx_min_q) tx_min_q <= sx;
					if (sy > ty_max_q) ty_max_q <= sy;
					if (sy < ty_min_q) ty_min_q <= sy;
				end
				chc_pkg::OP_CAL_END: begin
					cx_min_q <= tx_min_q;
					cy_min_q <= ty_min_q;
					cx_rng_q <= (tx_max_q >= tx_min_q) ? SB'(tx_max_q - tx_min_q) : '0;
					cy_rng_q <= (ty_max_q >= ty_min_q) ? SB'(ty_max_q - ty_min_q) : '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hx_q <= sx;
			hy_q <= sy;
		end
	end

	assign range_zero = (cx_rng_q == '0) || (cy_rng_q == '0);

	// divider: |d| * 2^17 / range, one quotient bit per cycle
	logic [NW-1:0] num_q, quo_q;
	logic [SB:0]   rem_q;
	logic [CW-1:0] dcnt_q;
	logic          dbusy_q, dneg_q, ddone_q, ddone;
	logic [SB:0]   dvs;
	logic signed [SB:0] diff;
	logic [SB:0]   dmag;
	logic [SB+1:0] trial;

	assign dvs  = {1'b0, cmd.sel_y ? cy_rng_q : cx_rng_q};
	assign diff = cmd.sel_y ? ((SB+1)'(hy_q) - (SB+1)'(cy_min_q))
	                        : ((SB+1)'(hx_q) - (SB+1)'(cx_min_q));
	assign dmag = diff[SB] ? (SB+1)'(-diff) : diff;
	assign trial = {rem_q, num_q[NW-1]} - {1'b0, dvs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
			ddone_q <= 1'b0;
		end else begin
			ddone_q <= dbusy_q && dcnt_q == CW'(1);
			if (cmd.start_div) begin
				dbusy_q <= 1'b1;
				dcnt_q <= CW'(NW);
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == CW'(1)) dbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			num_q <= {dmag, 17'd0};
			rem_q <= '0;
			quo_q <= '0;
			dneg_q <= diff[SB];
		end else if (dbusy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (!trial[SB+1]) begin
				rem_q <= trial[SB:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SB-1:0], num_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// quotient complete the cycle after the last shift
	assign ddone = ddone_q;

	// signed quotient minus one, saturated to q2.16
	logic signed [NW+1:0] qs, qn;
	logic signed [QW-1:0] qsat;
	assign qs = dneg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign qn = qs - (NW+2)'(65536);
	always_comb begin
		if (qn > (NW+2)'(131071)) qsat = 19'sd131071;
		else if (qn < -(NW+2)'(131072)) qsat = -19'sd131072;
		else qsat = QW'(qn);
	end

	logic signed [QW-1:0] nx_q;
	logic                 lastq;
	always_ff @(posedge clk) begin
		lastq <= 1'b0;
		if (ddone && !cmd.sel_y) nx_q <= qsat;
	end

	// cordic, vectoring, one step per cycle
	logic signed [XW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [SW-1:0] scnt_q;
	logic          cbusy_q;
	logic signed [XW-1:0] nx_e, ny_e;

	assign nx_e = XW'(nx_q);
	assign ny_e = XW'(qsat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbusy_q <= 1'b0;
			scnt_q <= '0;
		end else if (cmd.start_cordic) begin
			cbusy_q <= !(nx_e == '0 && ny_e == '0);
			scnt_q <= '0;
		end else if (cbusy_q) begin
			scnt_q <= scnt_q + 1'b1;
			if (scnt_q == SW'(CORDIC_STEPS - 1)) cbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_cordic) begin
			if (nx_e < 0) begin
				if (ny_e >= 0) begin
					cx_q <= ny_e; cy_q <= -nx_e; cz_q <= chc_pkg::DEG90;
				end else begin
					cx_q <= -ny_e; cy_q <= nx_e; cz_q <= -chc_pkg::DEG90;
				end
			end else begin
				cx_q <= nx_e; cy_q <= ny_e; cz_q <= '0;
			end
		end else if (cbusy_q) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + (cy_q >>> scnt_q);
				cy_q <= cy_q - (cx_q >>> scnt_q);
				cz_q <= cz_q + chc_pkg::atan_q16(5'(scnt_q));
			end else begin
				cx_q <= cx_q - (cy_q >>> scnt_q);
				cy_q <= cy_q + (cx_q >>> scnt_q);
				cz_q <= cz_q - chc_pkg::atan_q16(5'(scnt_q));
			end
		end
	end

	assign sts.div_done = ddone;
	assign sts.cordic_done = !cbusy_q && !ddone && !cmd.start_div && !lastq;

	// heading = floor((360*2^16 - z) / 2^16) mod 360, before offset
	logic signed [ZW:0] hq;
	logic [10:0] hi;
	always_comb begin
		hq = (ZW+1)'(chc_pkg::TURN_Q16) - (ZW+1)'(cz_q);
		if (hq < 0) hq = '0;
		hi = 11'(hq >>> 16);
		if (hi >= 11'(chc_pkg::FULL_TURN)) hi = hi - 11'(chc_pkg::FULL_TURN);
		heading = 9'(hi);
	end
endmodule
`default_nettype wire

// ===== rtl/compass_heading_with_minmax_cal.sv =====
// top level: compass heading with min/max calibration
`default_nettype none
// channel | direction | payload
// in      | input     | chc_pkg::in_beat_t (opcode, samples, ready, overflow)
// out     | output    | chc_pkg::out_beat_t (heading, fresh, range error)
// cfg     | input     | cfg_we / cfg_wdata, check_overflow
// a usable heading or zero beat with a nonzero calibration range runs the
// shared bit-serial divider for x, then for y, then the cordic loop; others
// answer with the last heading. one beat is in work at a time; the result
// sits in an output register while in_stall stays high until it is taken.
// reset is asynchronous and restores calibration defaults.
module compass_heading_with_minmax_cal #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  chc_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output chc_pkg::out_beat_t  out_data,
	input  wire                 cfg_we,
	input  wire                 cfg_wdata
);
	logic chk_q, busy, acc, go, usable;
	logic [2:0] op_q;
	logic [8:0] zoff_q, last_q, hdg;
	logic [9:0] sum;
	logic range_zero;
	chc_pkg::dp_cmd_t cmd;
	chc_pkg::dp_sts_t sts;

	assign in_stall = out_valid || busy;
	assign acc = in_valid && !in_stall;
	assign usable = in_data.data_ready && !(chk_q && in_data.overflow_flag);
	assign go = acc && (in_data.opcode == chc_pkg::OP_HEADING ||
		in_data.opcode == chc_pkg::OP_ZERO) && usable && !range_zero;

	chc_ctrl u_ctrl (.clk, .arst_n, .go, .sts, .cmd, .busy);

	chc_dpath #(.SAMPLE_BITS(chc_pkg::SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk, .arst_n, .load(acc), .op(in_data.opcode),
		.sx(in_data.sample_x), .sy(in_data.sample_y),
		.cmd, .sts, .range_zero, .heading(hdg)
	);

	always_comb begin
		sum = {1'b0, hdg} + 10'(chc_pkg::FULL_TURN)
			- ((op_q == chc_pkg::OP_ZERO) ? 10'd0 : {1'b0, zoff_q});
		if (sum >= 10'(chc_pkg::FULL_TURN)) sum = sum - 10'(chc_pkg::FULL_TURN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q <= 1'b1;
			zoff_q <= '0;
			last_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			op_q <= '0;
		end else begin
			if (cfg_we) chk_q <= cfg_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (acc) begin
				op_q <= in_data.opcode;
				if (!go) begin
					out_valid <= 1'b1;
					out_data.heading_deg <= last_q;
					out_data.fresh <= 1'b0;
					out_data.range_error <= (in_data.opcode == chc_pkg::OP_HEADING ||
						in_data.opcode == chc_pkg::OP_ZERO) && usable && range_zero;
					if (in_data.opcode == chc_pkg::OP_ZERO) zoff_q <= last_q;
				end
			end
			if (cmd.finish) begin
				last_q <= 9'(sum);
				if (op_q == chc_pkg::OP_ZERO) zoff_q <= 9'(sum);
				out_valid <= 1'b1;
				out_data.heading_deg <= 9'(sum);
				out_data.fresh <= 1'b1;
				out_data.range_error <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
